/* sv/rcfp_pkg.sv */
package rcfp_pkg;

    // Field widths of the channel and the packed frame.
    localparam int CHAN_W      = 12;
    localparam int SCALED_W    = 11;
    localparam int QUOT_W      = 13;
    localparam int PROD_W      = 28;
    localparam int RECIP_SHIFT = 15;
    localparam int HELD_W      = 3;
    localparam int ACC_W       = 7;
    localparam int PACK_W      = 18;
    localparam int TOTAL_W     = 5;
    localparam int CHAN_IDX_W  = 4;

    // Scaling: floor(v * 8 / 5) is (v * 52429) >> 15, exact for 12-bit v.
    localparam logic [15:0]         RECIP          = 16'd52429;
    localparam logic [QUOT_W-1:0]   CHANNEL_OFFSET = 13'd1408;
    localparam logic [QUOT_W-1:0]   CHANNEL_MAX    = 13'd2047;

    // Frame constants.
    localparam logic [CHAN_IDX_W-1:0] FIRST_CHANNEL = 4'd0;
    localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL  = 4'd15;
    localparam logic [7:0] SYNC_BYTE = 8'hEE;
    localparam logic [7:0] LEN_BYTE  = 8'd24;
    localparam logic [7:0] TYPE_BYTE = 8'h16;
    localparam logic [7:0] CRC_POLY  = 8'hD5;

    // Job queue between the packer and the byte sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One packed item: optional header, one or two payload bytes, optional CRC.
    typedef struct packed {
        logic       hdr;
        logic       two;
        logic       eof;
        logic [7:0] b0;
        logic [7:0] b1;
    } job_t;

    // Byte positions the sequencer walks through for one job.
    typedef enum logic [2:0] {
        SLOT_SYNC,
        SLOT_LEN,
        SLOT_TYPE,
        SLOT_PAY0,
        SLOT_PAY1,
        SLOT_CRC
    } slot_t;

    // CRC-8, polynomial 0xD5, MSB first, one byte.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* sv/rcfp_front.sv */
module rcfp_front
    import rcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              channel_valid,
    output logic              channel_stall,
    input  logic [CHAN_W-1:0] channel_value,
    output logic              push,
    output job_t              push_job,
    input  logic              q_full
);

    logic              p_valid_reg, p_valid_next;
    logic [QUOT_W-1:0] p_quot_reg;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [CHAN_IDX_W-1:0] ch_reg, ch_next;

    logic [PROD_W-1:0]   prod;
    logic                accept;
    logic [QUOT_W-1:0]   diff;
    logic [SCALED_W-1:0] scaled;
    logic [HELD_W-1:0]   held_eff;
    logic [ACC_W-1:0]    acc_eff;
    logic [PACK_W-1:0]   packed_bits;
    logic [TOTAL_W-1:0]  total;
    logic                two;
    logic                frame_start;
    logic                frame_end;

    // A transfer waits only while the scaled value cannot move into the queue.
    assign push          = p_valid_reg && !q_full;
    assign channel_stall = p_valid_reg && q_full;
    assign accept        = channel_valid && !channel_stall;

    // Scale by eight fifths through a reciprocal multiply.
    assign prod = PROD_W'(channel_value) * PROD_W'(RECIP);

    // Remove the offset and saturate to eleven bits.
    always_comb
    begin
        diff = p_quot_reg - CHANNEL_OFFSET;
        if (p_quot_reg < CHANNEL_OFFSET)
            scaled = '0;
        else if (diff > CHANNEL_MAX)
            scaled = CHANNEL_MAX[SCALED_W-1:0];
        else
            scaled = diff[SCALED_W-1:0];
    end

    // Append the value to the leftover bits and split off whole bytes.
    always_comb
    begin
        frame_start = (ch_reg == FIRST_CHANNEL);
        frame_end   = (ch_reg == LAST_CHANNEL);
        held_eff    = frame_start ? '0 : held_reg;
        acc_eff     = frame_start ? '0 : acc_reg;
        packed_bits = PACK_W'(acc_eff) | (PACK_W'(scaled) << held_eff);
        total       = TOTAL_W'(held_eff) + TOTAL_W'(SCALED_W);
        two         = total[TOTAL_W-1];

        push_job.hdr = frame_start;
        push_job.two = two;
        push_job.eof = frame_end;
        push_job.b0  = packed_bits[7:0];
        push_job.b1  = packed_bits[15:8];

        held_next = held_reg;
        acc_next  = acc_reg;
        ch_next   = ch_reg;
        if (push)
        begin
            if (frame_end)
            begin
                held_next = '0;
                acc_next  = '0;
                ch_next   = FIRST_CHANNEL;
            end
            else
            begin
                ch_next = ch_reg + 1'b1;
                if (two)
                begin
                    held_next = HELD_W'(total - TOTAL_W'(16));
                    acc_next  = ACC_W'(packed_bits[PACK_W-1:16]);
                end
                else
                begin
                    held_next = HELD_W'(total - TOTAL_W'(8));
                    acc_next  = packed_bits[8 +: ACC_W];
                end
            end
        end

        if (accept)
            p_valid_next = 1'b1;
        else if (push)
            p_valid_next = 1'b0;
        else
            p_valid_next = p_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            held_reg    <= '0;
            acc_reg     <= '0;
            ch_reg      <= FIRST_CHANNEL;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            held_reg    <= held_next;
            acc_reg     <= acc_next;
            ch_reg      <= ch_next;
        end
    end

    // Quotient register after the multiplier.
    always_ff @(posedge clk)
    begin
        if (accept)
            p_quot_reg <= prod[PROD_W-1:RECIP_SHIFT];
    end

endmodule

/* sv/rcfp_queue.sv */
module rcfp_queue
    import rcfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

/* sv/rcfp_back.sv */
module rcfp_back
    import rcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       frame_valid,
    input  logic       frame_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       end_of_frame
);

    slot_t      pos_reg, pos_next;
    logic       active_reg, active_next;
    logic [7:0] crc_reg, crc_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       eof_reg, eof_next;

    slot_t      slot;
    logic       emit;
    logic       is_last;

    assign frame_valid  = out_valid_reg;
    assign out_byte     = byte_reg;
    assign last_of_run  = last_reg;
    assign end_of_frame = eof_reg;

    // Walk the byte slots of the head job, one transfer per cycle while frame_stall is low.
    always_comb
    begin
        emit = head_valid && (!out_valid_reg || !frame_stall);
        if (active_reg)
            slot = pos_reg;
        else
            slot = head_job.hdr ? SLOT_SYNC : SLOT_PAY0;

        is_last   = 1'b0;
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        byte_next = byte_reg;
        case (slot)
            SLOT_SYNC:
            begin
                byte_next = SYNC_BYTE;
                pos_next  = SLOT_LEN;
            end
            SLOT_LEN:
            begin
                byte_next = LEN_BYTE;
                pos_next  = SLOT_TYPE;
            end
            SLOT_TYPE:
            begin
                byte_next = TYPE_BYTE;
                crc_next  = crc_feed(8'h00, TYPE_BYTE);
                pos_next  = SLOT_PAY0;
            end
            SLOT_PAY0:
            begin
                byte_next = head_job.b0;
                crc_next  = crc_feed(crc_reg, head_job.b0);
                if (head_job.two)
                    pos_next = SLOT_PAY1;
                else if (head_job.eof)
                    pos_next = SLOT_CRC;
                else
                    is_last = 1'b1;
            end
            SLOT_PAY1:
            begin
                byte_next = head_job.b1;
                crc_next  = crc_feed(crc_reg, head_job.b1);
                if (head_job.eof)
                    pos_next = SLOT_CRC;
                else
                    is_last = 1'b1;
            end
            SLOT_CRC:
            begin
                byte_next = crc_reg;
                is_last   = 1'b1;
            end
            default:
            begin
                is_last = 1'b1;
            end
        endcase

        last_next = is_last;
        eof_next  = (slot == SLOT_CRC);
        pop       = emit && is_last;

        if (emit)
            active_next = !is_last;
        else
            active_next = active_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (!frame_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Sequencer state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= SLOT_SYNC;
            active_reg    <= 1'b0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                pos_reg    <= pos_next;
                active_reg <= active_next;
                crc_reg    <= crc_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            eof_reg  <= eof_next;
        end
    end

endmodule

/* sv/rc_channel_frame_packer.sv */
// RC channel frame packer.
// The channel input takes one 12-bit pulse width per transfer, channels 0 to 15
// in turn; a transfer completes on a clock edge with channel_valid high and
// channel_stall low. Each value is scaled to floor(v*8/5)-1408, clamped to
// 0..2047 and packed LSB first. The frame output gives one byte per transfer
// (frame_valid high, frame_stall low): 0xEE, 24, 0x16, 22 payload bytes and a
// CRC-8 (poly 0xD5) over type and payload, with last_of_run on the final byte
// of each channel and end_of_frame on the CRC byte.
// The first byte caused by a channel passes the quotient register, the job
// queue and the output byte register. Throughput is bounded by the byte
// sequencer at one byte per cycle while frame_stall is low; a frame is 26 bytes.
// Channels may arrive every cycle unless stalled; a four-entry job queue
// absorbs the difference, and channel_stall rises only when that queue is full.
// While frame_stall is high the output byte holds and the sequencer waits.
// Reset clears the channel counter, bit store, CRC, queue and output valid;
// the next channel after reset starts a new frame.
module rc_channel_frame_packer
    import rcfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              channel_valid,
    output logic              channel_stall,
    input  logic [CHAN_W-1:0] channel_value,
    output logic              frame_valid,
    input  logic              frame_stall,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              end_of_frame
);

    logic q_push;
    job_t q_push_job;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;

    rcfp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_valid (channel_valid),
        .channel_stall (channel_stall),
        .channel_value (channel_value),
        .push          (q_push),
        .push_job      (q_push_job),
        .q_full        (q_full)
    );

    rcfp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    rcfp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_job     (q_head_job),
        .pop          (q_pop),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

    // The job queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("job queue read while empty");

    // The CRC byte always closes a channel's run.
    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && end_of_frame) |-> last_of_run)
        else $error("end of frame without end of run");

endmodule
